>>> hdl/pfm_pkg.sv
// shared types and constants for the pulse frequency to midi note block
// no dependencies; imported by the gate, mapper and top level modules
package pfm_pkg;

	localparam int CFG_INDEX_WIDTH = 3;
	localparam int CFG_DATA_WIDTH  = 24;
	localparam int INTERVAL_WIDTH  = 16;
	localparam int SPAN_CFG_WIDTH  = 24;
	localparam int NOTE_WIDTH      = 7;

	typedef enum logic [CFG_INDEX_WIDTH-1:0] {
		CFG_INTERVAL_MS   = 3'd0,
		CFG_NOTE_LOW      = 3'd1,
		CFG_NOTE_HIGH     = 3'd2,
		CFG_MIN_SPAN      = 3'd3,
		CFG_NOTE_VELOCITY = 3'd4,
		CFG_MIDI_CHANNEL  = 3'd5
	} cfg_index_t;

	localparam logic [INTERVAL_WIDTH-1:0] RST_INTERVAL_MS   = 16'd1000;
	localparam logic [NOTE_WIDTH-1:0]     RST_NOTE_LOW      = 7'd40;
	localparam logic [NOTE_WIDTH-1:0]     RST_NOTE_HIGH     = 7'd90;
	localparam logic [SPAN_CFG_WIDTH-1:0] RST_MIN_SPAN      = 24'd5;
	localparam logic [NOTE_WIDTH-1:0]     RST_NOTE_VELOCITY = 7'd100;
	localparam logic [3:0]                RST_MIDI_CHANNEL  = 4'd0;

	localparam logic [3:0] CIN_NOTE_OFF    = 4'h8;
	localparam logic [3:0] CIN_NOTE_ON     = 4'h9;
	localparam logic [3:0] STATUS_NOTE_OFF = 4'h8;
	localparam logic [3:0] STATUS_NOTE_ON  = 4'h9;

	// mapper result handed to the packet sequencer
	typedef struct packed {
		logic                  done;
		logic [NOTE_WIDTH-1:0] note;
	} map_res_t;

endpackage

>>> hdl/pfm_gate.sv
// gate window: saturating edge counter and millisecond timer
// depends on pfm_pkg
module pfm_gate import pfm_pkg::*; #(
	parameter int COUNT_WIDTH = 24,
	parameter int TIMER_WIDTH = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      accept,
	input  logic                      rising_edge,
	input  logic                      ms_tick,
	input  logic [INTERVAL_WIDTH-1:0] interval_ms,
	output logic                      win_end,
	output logic [COUNT_WIDTH-1:0]    count
);

	localparam int EW = (TIMER_WIDTH > INTERVAL_WIDTH) ? TIMER_WIDTH : INTERVAL_WIDTH;

	logic [COUNT_WIDTH-1:0] edge_count_q;
	logic [COUNT_WIDTH-1:0] edge_next;
	logic [TIMER_WIDTH-1:0] elapsed_q;
	logic [TIMER_WIDTH-1:0] elapsed_next;

	always_comb begin
		edge_next = edge_count_q;
		if (rising_edge && (edge_count_q != {COUNT_WIDTH{1'b1}}))
			edge_next = edge_count_q + COUNT_WIDTH'(1);
		elapsed_next = elapsed_q;
		if (elapsed_q != {TIMER_WIDTH{1'b1}})
			elapsed_next = elapsed_q + TIMER_WIDTH'(1);
		win_end = ms_tick && (EW'(elapsed_next) >= EW'(interval_ms));
		count   = edge_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_count_q <= '0;
			elapsed_q    <= '0;
		end else if (accept) begin
			if (win_end) begin
				edge_count_q <= '0;
				elapsed_q    <= '0;
			end else begin
				edge_count_q <= edge_next;
				if (ms_tick)
					elapsed_q <= elapsed_next;
			end
		end
	end

endmodule

>>> hdl/pfm_note_map.sv
// note mapper: min/max tracking, span test, one multiply and a shared
// subtract-compare unit that restores seven quotient bits; depends on pfm_pkg
module pfm_note_map import pfm_pkg::*; #(
	parameter int COUNT_WIDTH = 24
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [COUNT_WIDTH-1:0]    count,
	input  logic [NOTE_WIDTH-1:0]     note_low,
	input  logic [NOTE_WIDTH-1:0]     note_high,
	input  logic [SPAN_CFG_WIDTH-1:0] min_span,
	output map_res_t                  res
);

	localparam int SW = (COUNT_WIDTH > SPAN_CFG_WIDTH) ? COUNT_WIDTH : SPAN_CFG_WIDTH;
	localparam int RW = COUNT_WIDTH + NOTE_WIDTH;

	typedef enum logic [5:0] {
		M_IDLE  = 6'b000001,
		M_RANGE = 6'b000010,
		M_SPAN  = 6'b000100,
		M_MUL   = 6'b001000,
		M_DIV   = 6'b010000,
		M_FIN   = 6'b100000
	} map_state_t;

	map_state_t state_q;
	logic [COUNT_WIDTH-1:0] lowest_q;
	logic [COUNT_WIDTH-1:0] highest_q;
	logic [COUNT_WIDTH-1:0] cnt_q;
	logic [COUNT_WIDTH-1:0] span_q;
	logic [RW-1:0]          rem_q;
	logic [NOTE_WIDTH-1:0]  quo_q;
	logic [2:0]             bit_q;
	logic                   neg_q;
	logic [NOTE_WIDTH-1:0]  absdiff_q;
	logic                   done_q;
	logic [NOTE_WIDTH-1:0]  note_q;

	logic [COUNT_WIDTH-1:0] span_w;
	logic [COUNT_WIDTH-1:0] num_w;
	logic                   span_ok;
	logic [RW-1:0]          div_shift;
	logic                   div_fit;
	logic [RW-1:0]          product;
	logic signed [8:0]      note_sum;
	logic [NOTE_WIDTH-1:0]  note_clamp;

	always_comb begin
		span_w    = highest_q - lowest_q;
		num_w     = cnt_q - lowest_q;
		span_ok   = SW'(span_w) >= SW'(min_span);
		div_shift = RW'(span_q) << bit_q;
		div_fit   = rem_q >= div_shift;
		product   = RW'(rem_q[COUNT_WIDTH-1:0]) * RW'(absdiff_q);
		if (neg_q)
			note_sum = $signed({2'b00, note_low}) - $signed({2'b00, quo_q});
		else
			note_sum = $signed({2'b00, note_low}) + $signed({2'b00, quo_q});
		if (note_sum[8])
			note_clamp = '0;
		else if (note_sum[7])
			note_clamp = {NOTE_WIDTH{1'b1}};
		else
			note_clamp = note_sum[NOTE_WIDTH-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= M_IDLE;
			lowest_q  <= {COUNT_WIDTH{1'b1}};
			highest_q <= '0;
			done_q    <= 1'b0;
		end else begin
			unique case (state_q)
				M_IDLE: begin
					done_q <= 1'b0;
					if (start)
						state_q <= M_RANGE;
				end
				M_RANGE: begin
					if (cnt_q == '0) begin
						done_q  <= 1'b1;
						state_q <= M_IDLE;
					end else begin
						done_q <= 1'b0;
						if (cnt_q < lowest_q)
							lowest_q <= cnt_q;
						if (cnt_q > highest_q)
							highest_q <= cnt_q;
						state_q <= M_SPAN;
					end
				end
				M_SPAN: begin
					if (!span_ok || (span_w == '0)) begin
						done_q  <= 1'b1;
						state_q <= M_IDLE;
					end else begin
						done_q  <= 1'b0;
						state_q <= M_MUL;
					end
				end
				M_MUL: begin
					done_q  <= 1'b0;
					state_q <= M_DIV;
				end
				M_DIV: begin
					done_q <= 1'b0;
					if (bit_q == 3'd0)
						state_q <= M_FIN;
				end
				M_FIN: begin
					done_q  <= 1'b1;
					state_q <= M_IDLE;
				end
				default: begin
					done_q  <= 1'b0;
					state_q <= M_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			M_IDLE: begin
				if (start)
					cnt_q <= count;
			end
			M_RANGE: begin
				if (cnt_q == '0)
					note_q <= '0;
			end
			M_SPAN: begin
				span_q    <= span_w;
				rem_q     <= RW'(num_w);
				neg_q     <= note_high < note_low;
				absdiff_q <= (note_high < note_low) ? note_low - note_high
				                                    : note_high - note_low;
				if (!span_ok)
					note_q <= '0;
				else
					note_q <= note_low;
			end
			M_MUL: begin
				rem_q <= product;
				quo_q <= '0;
				bit_q <= 3'd6;
			end
			M_DIV: begin
				// restoring step: quotient never exceeds seven bits
				if (div_fit) begin
					rem_q        <= rem_q - div_shift;
					quo_q[bit_q] <= 1'b1;
				end
				bit_q <= bit_q - 3'd1;
			end
			M_FIN: begin
				note_q <= note_clamp;
			end
			default: ;
		endcase
	end

	assign res.done = done_q;
	assign res.note = note_q;

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == M_DIV) |-> (span_q != '0))
		else $error("divide step with zero span");
	a_range_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == M_SPAN) |-> (lowest_q <= highest_q))
		else $error("min count above max count");

endmodule

>>> hdl/pulse_frequency_to_midi_note_top.sv
// top level: configuration registers, packet sequencer and output register
// depends on pfm_pkg, pfm_gate and pfm_note_map
//
// Edges and millisecond ticks enter one word per cycle while no gate window
// is closing. A word whose tick closes the window drops in_ready until the
// note mapper is done, the longest path being the seven restoring steps of
// the shared subtract-compare unit, and until the midi packets have been
// handed to the output register, which may wait on out_ready. Up to two
// packets (note-off, then note-on) follow a window; last marks the final one.
// Configuration writes are always taken.
module pulse_frequency_to_midi_note_top import pfm_pkg::*; #(
	parameter int COUNT_WIDTH = 24,
	parameter int TIMER_WIDTH = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       rising_edge,
	input  logic                       ms_tick,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [3:0]                 usb_cin,
	output logic [7:0]                 status_byte,
	output logic [NOTE_WIDTH-1:0]      note_number,
	output logic [NOTE_WIDTH-1:0]      velocity,
	output logic                       last,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [CFG_DATA_WIDTH-1:0]  cfg_data
);

	typedef enum logic [3:0] {
		T_IDLE = 4'b0001,
		T_MAP  = 4'b0010,
		T_OFF  = 4'b0100,
		T_ON   = 4'b1000
	} top_state_t;

	top_state_t state_q;
	logic [INTERVAL_WIDTH-1:0] interval_ms_q;
	logic [NOTE_WIDTH-1:0]     note_low_q;
	logic [NOTE_WIDTH-1:0]     note_high_q;
	logic [SPAN_CFG_WIDTH-1:0] min_span_q;
	logic [NOTE_WIDTH-1:0]     note_velocity_q;
	logic [3:0]                midi_channel_q;
	logic [NOTE_WIDTH-1:0]     sounding_q;
	logic [NOTE_WIDTH-1:0]     off_note_q;
	logic [NOTE_WIDTH-1:0]     on_note_q;
	logic                      out_valid_q;
	logic [3:0]                usb_cin_q;
	logic [7:0]                status_q;
	logic [NOTE_WIDTH-1:0]     note_number_q;
	logic [NOTE_WIDTH-1:0]     velocity_q;
	logic                      last_q;

	logic                   in_accept;
	logic                   win_end;
	logic [COUNT_WIDTH-1:0] win_count;
	map_res_t               map_res;
	logic                   slot_free;

	assign in_ready  = (state_q == T_IDLE);
	assign in_accept = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign slot_free = !out_valid_q || out_ready;

	pfm_gate #(
		.COUNT_WIDTH (COUNT_WIDTH),
		.TIMER_WIDTH (TIMER_WIDTH)
	) u_gate (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (in_accept),
		.rising_edge (rising_edge),
		.ms_tick     (ms_tick),
		.interval_ms (interval_ms_q),
		.win_end     (win_end),
		.count       (win_count)
	);

	pfm_note_map #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_map (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (in_accept && win_end),
		.count     (win_count),
		.note_low  (note_low_q),
		.note_high (note_high_q),
		.min_span  (min_span_q),
		.res       (map_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_ms_q   <= RST_INTERVAL_MS;
			note_low_q      <= RST_NOTE_LOW;
			note_high_q     <= RST_NOTE_HIGH;
			min_span_q      <= RST_MIN_SPAN;
			note_velocity_q <= RST_NOTE_VELOCITY;
			midi_channel_q  <= RST_MIDI_CHANNEL;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_INTERVAL_MS:   interval_ms_q   <= cfg_data[INTERVAL_WIDTH-1:0];
				CFG_NOTE_LOW:      note_low_q      <= cfg_data[NOTE_WIDTH-1:0];
				CFG_NOTE_HIGH:     note_high_q     <= cfg_data[NOTE_WIDTH-1:0];
				CFG_MIN_SPAN:      min_span_q      <= cfg_data[SPAN_CFG_WIDTH-1:0];
				CFG_NOTE_VELOCITY: note_velocity_q <= cfg_data[NOTE_WIDTH-1:0];
				CFG_MIDI_CHANNEL:  midi_channel_q  <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// packet sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= T_IDLE;
			sounding_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (((state_q == T_OFF) || (state_q == T_ON)) && slot_free)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				T_IDLE: begin
					if (in_accept && win_end)
						state_q <= T_MAP;
				end
				T_MAP: begin
					if (map_res.done) begin
						if (map_res.note != sounding_q) begin
							sounding_q <= map_res.note;
							if (sounding_q != '0)
								state_q <= T_OFF;
							else
								state_q <= T_ON;
						end else begin
							state_q <= T_IDLE;
						end
					end
				end
				T_OFF: begin
					if (slot_free)
						state_q <= (on_note_q != '0) ? T_ON : T_IDLE;
				end
				T_ON: begin
					if (slot_free)
						state_q <= T_IDLE;
				end
				default: state_q <= T_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == T_MAP) && map_res.done) begin
			off_note_q <= sounding_q;
			on_note_q  <= map_res.note;
		end
		if ((state_q == T_OFF) && slot_free) begin
			usb_cin_q     <= CIN_NOTE_OFF;
			status_q      <= {STATUS_NOTE_OFF, midi_channel_q};
			note_number_q <= off_note_q;
			velocity_q    <= '0;
			last_q        <= (on_note_q == '0);
		end else if ((state_q == T_ON) && slot_free) begin
			usb_cin_q     <= CIN_NOTE_ON;
			status_q      <= {STATUS_NOTE_ON, midi_channel_q};
			note_number_q <= on_note_q;
			velocity_q    <= note_velocity_q;
			last_q        <= 1'b1;
		end
	end

	assign out_valid   = out_valid_q;
	assign usb_cin     = usb_cin_q;
	assign status_byte = status_q;
	assign note_number = note_number_q;
	assign velocity    = velocity_q;
	assign last        = last_q;

	a_done_in_map: assert property (@(posedge clk) disable iff (!arst_n)
		map_res.done |-> (state_q == T_MAP))
		else $error("mapper result outside map wait");
	a_on_note: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == T_ON) |-> (on_note_q != '0))
		else $error("note-on for silence");
	a_off_note: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == T_OFF) |-> (off_note_q != '0))
		else $error("note-off with no sounding note");
	a_mid_word_off: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !last_q) |-> (usb_cin_q == CIN_NOTE_OFF))
		else $error("only a note-off can precede another word");

endmodule
